// ===== hw/rtl/mkds_pkg.sv =====
// Shared constants, codes and control types for the matrix keypad debounce scanner.
package mkds_pkg;

    localparam int KEY_CAP      = 24;
    localparam int KEY_W        = 5;
    localparam int TICK_W       = 32;
    localparam int HOLD_W       = 16;
    localparam int MASK_W       = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int S_TDATA_W    = 56;
    localparam int M_TDATA_W    = 8;

    localparam int DEF_NUM_ROWS = 4;
    localparam int DEF_NUM_COLS = 6;

    localparam logic [HOLD_W-1:0] HOLD_TIME_RST    = 16'd20;
    localparam logic [MASK_W-1:0] PRESENT_MASK_RST = 24'h7FFF7F;
    localparam logic [MASK_W-1:0] RELEASE_MASK_RST = 24'h080042;

    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MASK = 2'd2;

    localparam logic [1:0] PH_RELEASED = 2'd0;
    localparam logic [1:0] PH_PRESSED  = 2'd1;
    localparam logic [1:0] PH_HELD     = 2'd2;
    localparam logic [1:0] PH_IDLE     = 2'd3;

    localparam logic EV_HELD     = 1'b0;
    localparam logic EV_RELEASED = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic flush;
    } mkds_cmd_t;

    typedef struct packed {
        logic can_step;
        logic last_key;
    } mkds_stat_t;

endpackage

// ===== hw/rtl/mkds_ctrl.sv =====
// Sequencer for the keypad scanner: accept, per-key scan, final flush.
module mkds_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mkds_pkg::mkds_stat_t stat,
    output mkds_pkg::mkds_cmd_t  cmd
);
    import mkds_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.can_step)
                begin
                    cmd.step = 1'b1;
                    if (stat.last_key)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (stat.can_step)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/mkds_dp.sv =====
// Datapath: config registers, per-key debounce state, event holding and output register.
module mkds_dp
#(
    parameter int NUM_KEYS = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mkds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mkds_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [mkds_pkg::TICK_W-1:0]         in_now_tick,
    input  logic [mkds_pkg::MASK_W-1:0]         in_closed_keys,
    input  mkds_pkg::mkds_cmd_t                 cmd,
    output mkds_pkg::mkds_stat_t                stat,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [mkds_pkg::KEY_W-1:0]          out_key_index,
    output logic                                out_event_kind,
    output logic                                out_last_event
);
    import mkds_pkg::*;

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CNT_W = $clog2(NUM_KEYS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_KEYS - 1);

    // configuration
    logic [HOLD_W-1:0] hold_time_reg;
    logic [MASK_W-1:0] present_mask_reg;
    logic [MASK_W-1:0] release_mask_reg;

    // per-key state
    logic [1:0]        phase_reg [NUM_KEYS];
    logic [TICK_W-1:0] start_reg [NUM_KEYS];

    // current scan
    logic [TICK_W-1:0]   now_reg;
    logic [NUM_KEYS-1:0] closed_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    // one event held back until we know whether another follows
    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic [KEY_W-1:0] pend_key_reg;
    logic             pend_kind_reg;

    logic             m_valid_reg;
    logic             m_valid_next;
    logic [KEY_W-1:0] m_key_reg;
    logic             m_kind_reg;
    logic             m_last_reg;

    logic [IDX_W-1:0]    idx;
    logic [NUM_KEYS-1:0] present_vec;
    logic [NUM_KEYS-1:0] release_vec;
    logic [1:0]          cur_phase;
    logic [1:0]          new_phase;
    logic                cur_closed;
    logic [TICK_W-1:0]   elapsed;
    logic                timed_out;
    logic                write_start;
    logic                ev_held;
    logic                ev_rel;
    logic                ev_new;
    logic                ev_kind;
    logic                push;
    logic                push_last;

    assign idx         = cnt_reg[IDX_W-1:0];
    assign present_vec = present_mask_reg[NUM_KEYS-1:0];
    assign release_vec = release_mask_reg[NUM_KEYS-1:0];
    assign cur_phase   = phase_reg[idx];
    assign cur_closed  = closed_reg[idx];
    assign elapsed     = now_reg - start_reg[idx];
    assign timed_out   = elapsed > TICK_W'(hold_time_reg);

    always_comb
    begin
        new_phase   = cur_phase;
        write_start = 1'b0;
        ev_held     = 1'b0;
        ev_rel      = 1'b0;
        case (cur_phase)
            PH_RELEASED:
            begin
                if (cur_closed)
                begin
                    new_phase   = PH_PRESSED;
                    write_start = 1'b1;
                end
            end
            PH_PRESSED:
            begin
                if (timed_out)
                begin
                    new_phase = PH_HELD;
                    ev_held   = 1'b1;
                end
                else if (!cur_closed)
                begin
                    new_phase = PH_RELEASED;
                end
            end
            PH_HELD:
            begin
                if (!cur_closed)
                begin
                    new_phase   = PH_IDLE;
                    write_start = 1'b1;
                end
            end
            default:
            begin
                if (timed_out)
                begin
                    new_phase = PH_RELEASED;
                    ev_rel    = 1'b1;
                end
                else if (cur_closed)
                begin
                    new_phase = PH_HELD;
                end
            end
        endcase
    end

    // unreported releases just drop their change flag
    assign ev_new  = cmd.step && present_vec[idx] && (ev_held || (ev_rel && release_vec[idx]));
    assign ev_kind = ev_held ? EV_HELD : EV_RELEASED;

    assign push      = (ev_new || cmd.flush) && pend_valid_reg;
    assign push_last = cmd.flush;

    assign stat.can_step = !m_valid_reg || out_ready;
    assign stat.last_key = (cnt_reg == LAST_CNT);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (ev_new)
        begin
            pend_valid_next = 1'b1;
        end
        else if (cmd.flush)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (push)
        begin
            m_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_time_reg    <= HOLD_TIME_RST;
            present_mask_reg <= PRESENT_MASK_RST;
            release_mask_reg <= RELEASE_MASK_RST;
            cnt_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                phase_reg[k] <= PH_RELEASED;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HOLD_TIME:    hold_time_reg    <= cfg_wdata[HOLD_W-1:0];
                    REG_PRESENT_MASK: present_mask_reg <= cfg_wdata[MASK_W-1:0];
                    REG_RELEASE_MASK: release_mask_reg <= cfg_wdata[MASK_W-1:0];
                    default:          ;
                endcase
            end
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cmd.step && present_vec[idx])
            begin
                phase_reg[idx] <= new_phase;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg    <= in_now_tick;
            closed_reg <= in_closed_keys[NUM_KEYS-1:0];
        end
        if (cmd.step && present_vec[idx] && write_start)
        begin
            start_reg[idx] <= now_reg;
        end
        if (ev_new)
        begin
            pend_key_reg  <= KEY_W'(idx);
            pend_kind_reg <= ev_kind;
        end
        if (push)
        begin
            m_key_reg  <= pend_key_reg;
            m_kind_reg <= pend_kind_reg;
            m_last_reg <= push_last;
        end
    end

    assign out_valid      = m_valid_reg;
    assign out_key_index  = m_key_reg;
    assign out_event_kind = m_kind_reg;
    assign out_last_event = m_last_reg;

endmodule

// ===== hw/rtl/matrix_keypad_debounce_scanner.sv =====
// Top level of the matrix keypad debounce scanner.
//
//  channel   dir  handshake                    content
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: now_tick[31:0], closed_keys[55:32]
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: key_index[4:0]; tuser: event_kind;
//                                              tlast: last_event
//  cfg       in   cfg_we                       cfg_index selects register, cfg_wdata value
//
// A scan accepts the input, steps each key in turn through the shared debounce/compare unit,
// then releases the final event.
// Each key step and the final step wait while an event sits untaken in the output register.
// Reset: all keys released, registers at their defaults, no transfer pending.
// s_axis_tready is high only between scans.
module matrix_keypad_debounce_scanner
#(
    parameter int NUM_ROWS = mkds_pkg::DEF_NUM_ROWS,
    parameter int NUM_COLS = mkds_pkg::DEF_NUM_COLS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mkds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mkds_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mkds_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // now_tick[31:0], closed_keys[55:32]
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mkds_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // key_index[4:0], zero[7:5]
    output logic                            m_axis_tuser,   // event_kind[0]
    output logic                            m_axis_tlast
);
    import mkds_pkg::*;

    localparam int KEY_SLOTS = (NUM_ROWS * NUM_COLS < KEY_CAP) ? NUM_ROWS * NUM_COLS : KEY_CAP;

    mkds_cmd_t        cmd;
    mkds_stat_t       stat;
    logic [KEY_W-1:0] key_index;

    mkds_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mkds_dp
    #(
        .NUM_KEYS (KEY_SLOTS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_now_tick    (s_axis_tdata[TICK_W-1:0]),
        .in_closed_keys (s_axis_tdata[TICK_W+MASK_W-1:TICK_W]),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_key_index  (key_index),
        .out_event_kind (m_axis_tuser),
        .out_last_event (m_axis_tlast)
    );

    assign m_axis_tdata = {{(M_TDATA_W - KEY_W){1'b0}}, key_index};

endmodule

// ===== hw/rtl/mkds_chk.sv =====
// Port-level checks for the keypad scanner, bound to the top level.
module mkds_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mkds_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);
    import mkds_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // one scan at a time
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a transfer");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[KEY_W-1:0] < KEY_W'(KEY_CAP))
        else $error("key index out of range");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:KEY_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind matrix_keypad_debounce_scanner mkds_chk u_mkds_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
